FILE: hdl/laau_pkg.sv
// Package with the shared constants and types of the left/above average unfilter.
package laau_pkg;

  localparam int unsigned MAX_WIDTH    = 4096;
  localparam int unsigned MAX_CHANNELS = 4;
  localparam int unsigned STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;

  localparam int unsigned ADDR_W   = $clog2(STORE_DEPTH);
  localparam int unsigned COL_W    = $clog2(MAX_WIDTH);
  localparam int unsigned CH_W     = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WIDTH_W  = 13;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_PER_PIXEL = 2'd2;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } laau_wr_t;

  typedef struct packed {
    logic [BYTE_W-1:0] residual;
    logic [CH_W-1:0]   ch;
    logic [ADDR_W-1:0] addr;
    logic              col_zero;
    logic              row_zero;
    logic              last;
  } laau_stage_t;

endpackage

FILE: hdl/laau_if.sv
// Stream interfaces for residual bytes in and reconstructed bytes out.
interface laau_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] residual_byte;

  modport source (output valid, output residual_byte, input ready);
  modport sink (input valid, input residual_byte, output ready);
endinterface

interface laau_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       last_of_image;

  modport source (output valid, output pixel_byte, output last_of_image, input ready);
  modport sink (input valid, input pixel_byte, input last_of_image, output ready);
endinterface

FILE: hdl/left_above_average_unfilter_top.sv
// Top level of the left/above average unfilter with position counters and result register.

// The block takes one residual byte per clock and gives one reconstructed byte per clock
// while the output does not stall. At acceptance the byte's column, channel and row select
// its prediction case and the line store (16384 x 8, one write and one registered read port)
// is read for the byte above; in the next stage the prediction is added and the result is
// written both to the line store and to the output register. The line store needs no
// clearing pass after reset. Configuration takes effect at the next byte.
module left_above_average_unfilter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  laau_in_if.sink                           in_i,
  laau_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [laau_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [laau_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [laau_pkg::WIDTH_W-1:0]  width_q;
  logic [laau_pkg::HEIGHT_W-1:0] height_q;
  logic [laau_pkg::CHAN_W-1:0]   chan_q;

  logic [laau_pkg::WIDTH_W-1:0]  eff_w;
  logic [laau_pkg::HEIGHT_W-1:0] eff_h;
  logic [laau_pkg::CHAN_W-1:0]   eff_c;

  logic [laau_pkg::CH_W-1:0]     ch_q, ch_d;
  logic [laau_pkg::COL_W-1:0]    col_q, col_d;
  logic [laau_pkg::HEIGHT_W-1:0] row_q, row_d;
  logic                          last_d;

  logic [laau_pkg::CHAN_W-1:0]     ch_p1;
  logic [laau_pkg::WIDTH_W-1:0]    col_p1;
  logic [laau_pkg::HEIGHT_W:0]     row_p1;
  logic [laau_pkg::ADDR_W-1:0]     col_scaled;
  logic [laau_pkg::ADDR_W-1:0]     rd_addr;

  logic                  s1_valid_q;
  laau_pkg::laau_stage_t s1_q, s1_d;
  logic                  s1_adv;
  logic                  out_free;
  logic                  in_acc;

  logic [laau_pkg::BYTE_W-1:0] left_q [laau_pkg::MAX_CHANNELS];
  logic [laau_pkg::BYTE_W-1:0] above;
  logic [laau_pkg::BYTE_W-1:0] left;
  logic [laau_pkg::BYTE_W:0]   avg_sum;
  logic [laau_pkg::BYTE_W-1:0] pred;
  logic [laau_pkg::BYTE_W-1:0] value;

  logic                        out_valid_q;
  logic [laau_pkg::BYTE_W-1:0] pixel_q;
  logic                        last_q;

  laau_pkg::laau_wr_t wr;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= laau_pkg::WIDTH_W'(1);
      height_q <= laau_pkg::HEIGHT_W'(1);
      chan_q   <= laau_pkg::CHAN_W'(laau_pkg::MAX_CHANNELS);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        laau_pkg::CFG_IMAGE_WIDTH:        width_q  <= cfg_data_i[laau_pkg::WIDTH_W-1:0];
        laau_pkg::CFG_IMAGE_HEIGHT:       height_q <= cfg_data_i[laau_pkg::HEIGHT_W-1:0];
        laau_pkg::CFG_CHANNELS_PER_PIXEL: chan_q   <= cfg_data_i[laau_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      eff_w = laau_pkg::WIDTH_W'(1);
    end else if (width_q > laau_pkg::WIDTH_W'(laau_pkg::MAX_WIDTH)) begin
      eff_w = laau_pkg::WIDTH_W'(laau_pkg::MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    eff_h = (height_q == '0) ? laau_pkg::HEIGHT_W'(1) : height_q;
    if (chan_q == '0) begin
      eff_c = laau_pkg::CHAN_W'(1);
    end else if (chan_q > laau_pkg::CHAN_W'(laau_pkg::MAX_CHANNELS)) begin
      eff_c = laau_pkg::CHAN_W'(laau_pkg::MAX_CHANNELS);
    end else begin
      eff_c = chan_q;
    end
  end

  // Handshake and stage advance.
  assign out_free  = !out_valid_q || out_o.ready;
  assign s1_adv    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc    = in_i.valid && in_i.ready;

  // Position advance and line store address of the byte at the input.
  always_comb begin
    ch_p1  = laau_pkg::CHAN_W'(ch_q) + laau_pkg::CHAN_W'(1);
    col_p1 = laau_pkg::WIDTH_W'(col_q) + laau_pkg::WIDTH_W'(1);
    row_p1 = (laau_pkg::HEIGHT_W+1)'(row_q) + (laau_pkg::HEIGHT_W+1)'(1);
    ch_d   = ch_q;
    col_d  = col_q;
    row_d  = row_q;
    last_d = 1'b0;
    if (ch_p1 >= eff_c) begin
      ch_d = '0;
      if (col_p1 >= eff_w) begin
        col_d = '0;
        if (row_p1 >= (laau_pkg::HEIGHT_W+1)'(eff_h)) begin
          row_d  = '0;
          last_d = 1'b1;
        end else begin
          row_d = row_p1[laau_pkg::HEIGHT_W-1:0];
        end
      end else begin
        col_d = col_p1[laau_pkg::COL_W-1:0];
      end
    end else begin
      ch_d = ch_p1[laau_pkg::CH_W-1:0];
    end

    case (eff_c)
      3'd1:    col_scaled = laau_pkg::ADDR_W'(col_q);
      3'd2:    col_scaled = laau_pkg::ADDR_W'({col_q, 1'b0});
      3'd3:    col_scaled = laau_pkg::ADDR_W'({col_q, 1'b0}) + laau_pkg::ADDR_W'(col_q);
      default: col_scaled = laau_pkg::ADDR_W'({col_q, 2'b00});
    endcase
    rd_addr = col_scaled + laau_pkg::ADDR_W'(ch_q);

    s1_d.residual = in_i.residual_byte;
    s1_d.ch       = ch_q;
    s1_d.addr     = rd_addr;
    s1_d.col_zero = (col_q == '0);
    s1_d.row_zero = (row_q == '0);
    s1_d.last     = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q       <= '0;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        ch_q  <= ch_d;
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  laau_line_buf u_line_buf (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (in_acc),
    .rd_addr_i (rd_addr),
    .rd_data_o (above)
  );

  // Prediction and reconstruction.
  always_comb begin
    left    = left_q[s1_q.ch];
    avg_sum = {1'b0, left} + {1'b0, above};
    if (s1_q.row_zero) begin
      pred = s1_q.col_zero ? '0 : left;
    end else begin
      pred = s1_q.col_zero ? above : avg_sum[laau_pkg::BYTE_W:1];
    end
    value   = s1_q.residual + pred;
    wr.en   = s1_adv;
    wr.addr = s1_q.addr;
    wr.data = value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < laau_pkg::MAX_CHANNELS; i++) begin
        left_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        left_q[s1_q.ch] <= value;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pixel_q <= value;
      last_q  <= s1_q.last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pixel_byte    = pixel_q;
  assign out_o.last_of_image = last_q;

`ifndef SYNTH
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while the pipeline is full and the output stalls");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted beat did not reach the read stage");

  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("reconstructed beat did not reach the output register");
`endif

endmodule

FILE: hdl/laau_line_buf.sv
// Line store of reconstructed bytes with one write port and one registered read port.
module laau_line_buf (
  input  logic                           clk_i,
  input  laau_pkg::laau_wr_t             wr_i,
  input  logic                           rd_en_i,
  input  logic [laau_pkg::ADDR_W-1:0]    rd_addr_i,
  output logic [laau_pkg::BYTE_W-1:0]    rd_data_o
);

  logic [laau_pkg::BYTE_W-1:0] mem [laau_pkg::STORE_DEPTH];
  logic [laau_pkg::BYTE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // A write to the address being read in the same cycle is bypassed to the read data.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
        rd_data_q <= wr_i.data;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the left/above average unfilter with a scoreboard-based predictor.
module testbench;

  localparam int unsigned WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [laau_pkg::BYTE_W-1:0] pixel_byte;
    logic                        last_of_image;
  } pixel_beat_t;

  class unfilter_scoreboard;
    logic [laau_pkg::BYTE_W-1:0]   line_store [laau_pkg::STORE_DEPTH];
    logic [laau_pkg::BYTE_W-1:0]   left_bytes [laau_pkg::MAX_CHANNELS];
    logic [laau_pkg::WIDTH_W-1:0]  width_reg;
    logic [laau_pkg::HEIGHT_W-1:0] height_reg;
    logic [laau_pkg::CHAN_W-1:0]   chan_reg;
    logic [laau_pkg::COL_W-1:0]    col;
    logic [laau_pkg::HEIGHT_W-1:0] row;
    logic [laau_pkg::CH_W-1:0]     chan;
    pixel_beat_t                   expected_q[$];
    int unsigned                   mismatches;

    function new();
      foreach (line_store[i]) line_store[i] = '0;
      foreach (left_bytes[i]) left_bytes[i] = '0;
      width_reg  = laau_pkg::WIDTH_W'(1);
      height_reg = laau_pkg::HEIGHT_W'(1);
      chan_reg   = laau_pkg::CHAN_W'(laau_pkg::MAX_CHANNELS);
      col        = '0;
      row        = '0;
      chan       = '0;
      mismatches = 0;
    endfunction

    function void write_register(logic [laau_pkg::CFG_IDX_W-1:0] idx,
                                 logic [laau_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        laau_pkg::CFG_IMAGE_WIDTH:        width_reg = data[laau_pkg::WIDTH_W-1:0];
        laau_pkg::CFG_IMAGE_HEIGHT:       height_reg = data[laau_pkg::HEIGHT_W-1:0];
        laau_pkg::CFG_CHANNELS_PER_PIXEL: chan_reg = data[laau_pkg::CHAN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > laau_pkg::MAX_WIDTH) return laau_pkg::MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int unsigned eff_channels();
      if (chan_reg == 0) return 1;
      if (chan_reg > laau_pkg::MAX_CHANNELS) return laau_pkg::MAX_CHANNELS;
      return chan_reg;
    endfunction

    function int unsigned image_bytes();
      return eff_width() * eff_height() * eff_channels();
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Reconstructs one byte and advances the raster position.
    function void note_residual(logic [laau_pkg::BYTE_W-1:0] residual);
      int unsigned c;
      int unsigned addr;
      int unsigned left_v;
      int unsigned above_v;
      int unsigned pred;
      pixel_beat_t beat;
      c = eff_channels();
      addr = (col * c + chan) % laau_pkg::STORE_DEPTH;
      left_v = left_bytes[chan];
      above_v = line_store[addr];
      if (row == 0) begin
        pred = (col == 0) ? 0 : left_v;
      end else begin
        pred = (col == 0) ? above_v : ((left_v + above_v) >> 1);
      end
      beat.pixel_byte = residual + pred[laau_pkg::BYTE_W-1:0];
      beat.last_of_image = 1'b0;
      line_store[addr] = beat.pixel_byte;
      left_bytes[chan] = beat.pixel_byte;
      if (chan + 1 >= c) begin
        chan = '0;
        if (col + 1 >= eff_width()) begin
          col = '0;
          if (row + 1 >= eff_height()) begin
            row = '0;
            beat.last_of_image = 1'b1;
          end else begin
            row = row + 1'b1;
          end
        end else begin
          col = col + 1'b1;
        end
      end else begin
        chan = chan + 1'b1;
      end
      expected_q.push_back(beat);
    endfunction

    function void check_result(logic [laau_pkg::BYTE_W-1:0] pixel, logic last);
      pixel_beat_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: output beat with nothing expected, pixel_byte=%h last_of_image=%b",
                 $time, pixel, last);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (pixel !== want.pixel_byte) begin
        $display("%0t: pixel_byte expected %h actual %h", $time, want.pixel_byte, pixel);
        mismatches++;
      end
      if (last !== want.last_of_image) begin
        $display("%0t: last_of_image expected %b actual %b", $time, want.last_of_image, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [laau_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [laau_pkg::CFG_DATA_W-1:0] cfg_data;
  bit                              idle_enable = 1'b1;
  int unsigned                     hold_request = 0;
  int unsigned                     quiet_cycles = 0;

  unfilter_scoreboard sb = new();

  laau_in_if  in_if();
  laau_out_if out_if();

  left_above_average_unfilter_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_residual(in_if.residual_byte);
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.pixel_byte, out_if.last_of_image);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Output side: random stall bursts plus one long hold on request.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        out_if.ready = 1'b0;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  function automatic logic [laau_pkg::BYTE_W-1:0] random_residual();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return laau_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_residual(input logic [laau_pkg::BYTE_W-1:0] residual);
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.residual_byte = residual;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic send_image(input int unsigned beats);
    repeat (beats) send_residual(random_residual());
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [laau_pkg::CFG_IDX_W-1:0] idx,
                                input logic [laau_pkg::CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(posedge clk);
    sb.write_register(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input int unsigned width, input int unsigned height,
                           input int unsigned channels);
    wait_drained();
    write_register(laau_pkg::CFG_IMAGE_WIDTH, laau_pkg::CFG_DATA_W'(width));
    write_register(laau_pkg::CFG_IMAGE_HEIGHT, laau_pkg::CFG_DATA_W'(height));
    write_register(laau_pkg::CFG_CHANNELS_PER_PIXEL, laau_pkg::CFG_DATA_W'(channels));
  endtask

  initial begin
    logic [laau_pkg::BYTE_W-1:0] directed_q[$];
    int unsigned random_beats;
    int unsigned image_count;
    int unsigned beats;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = laau_pkg::CFG_IMAGE_WIDTH;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.residual_byte = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset setting: a single pixel of four channels passes through.
    directed_q = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    foreach (directed_q[i]) send_residual(directed_q[i]);

    configure(3, 2, 2);
    directed_q = '{8'hFF, 8'h01, 8'hFF, 8'hFF, 8'h80, 8'h00,
                   8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h80};
    foreach (directed_q[i]) send_residual(directed_q[i]);

    // Zero registers act as one.
    configure(0, 0, 0);
    send_residual(8'hA5);

    // Channel count above the maximum acts as four.
    configure(2, 1, 7);
    directed_q = '{8'h10, 8'h20, 8'h30, 8'h40, 8'hF0, 8'hE0, 8'hD0, 8'hC0};
    foreach (directed_q[i]) send_residual(directed_q[i]);

    random_beats = 0;
    image_count = 0;
    while (random_beats < 1050) begin
      idle_enable = (random_beats < 880) && ($urandom_range(0, 3) != 0);
      case (image_count)
        3: begin
          // A tall image whose height is lowered below the current row ends at once.
          configure(1, 16'hFFFF, 1);
          repeat (20) send_residual(random_residual());
          wait_drained();
          write_register(laau_pkg::CFG_IMAGE_HEIGHT, laau_pkg::CFG_DATA_W'(5));
          send_residual(random_residual());
        end
        6: begin
          // Width lowered mid-row: the column past the new width wraps to the next row.
          configure(10, 3, 3);
          repeat (54) send_residual(random_residual());
          wait_drained();
          write_register(laau_pkg::CFG_IMAGE_WIDTH, laau_pkg::CFG_DATA_W'(4));
          repeat (15) send_residual(random_residual());
        end
        9: begin
          // Width above the maximum keeps the row open, with a long output hold that
          // backs up the input; the row is then closed by lowering the width.
          configure(16'h1FFF, 1, 1);
          hold_request = 300;
          repeat (40) send_residual(random_residual());
          wait_drained();
          write_register(laau_pkg::CFG_IMAGE_WIDTH, laau_pkg::CFG_DATA_W'(41));
          send_residual(random_residual());
        end
        default: begin
          if (image_count == 0 || $urandom_range(0, 2) != 0) begin
            configure(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12),
                      ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5),
                      $urandom_range(0, 7));
          end
          beats = sb.image_bytes();
          send_image(beats);
          random_beats += beats;
        end
      endcase
      image_count++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
